FILE: rtl/ole_pkg.sv
// ole_pkg: shared types and constants of the ordered list engine
// command and status codes, field widths, compare result type
// no dependencies
package ole_pkg;

  // field widths of one command beat and one result beat
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned KEY_W    = 32;
  localparam int unsigned POS_W    = 8;
  localparam int unsigned INDEX_W  = 8;
  localparam int unsigned COUNT_W  = 9;
  localparam int unsigned STATUS_W = 2;

  localparam int unsigned DEFAULT_CAPACITY = 256;

  // command codes
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SWAP   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FIND   = 2'd2;
  localparam logic [CMD_W-1:0] CMD_MIN    = 2'd3;

  // status codes
  localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_RANGE = 2'd2;

  // result of the shared compare unit
  typedef struct packed {
    logic eq;
    logic lt;
  } cmp_res_t;

endpackage

FILE: rtl/ole_mem.sv
// ole_mem: list store, one write port and one read port with registered data
// depends on ole_pkg for the entry width and the default depth
module ole_mem #(
  parameter int unsigned DEPTH = ole_pkg::DEFAULT_CAPACITY,
  parameter int unsigned AW    = 8
) (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [AW-1:0]             waddr_i,
  input  logic [ole_pkg::KEY_W-1:0] wdata_i,
  input  logic                      re_i,
  input  logic [AW-1:0]             raddr_i,
  output logic [ole_pkg::KEY_W-1:0] rdata_o
);

  logic [ole_pkg::KEY_W-1:0] mem_q [DEPTH];
  logic [ole_pkg::KEY_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/ole_cmp.sv
// ole_cmp: shared compare unit, equality and signed less-than of two entries
// depends on ole_pkg for the entry width and the result type
module ole_cmp (
  input  logic signed [ole_pkg::KEY_W-1:0] a_i,
  input  logic signed [ole_pkg::KEY_W-1:0] b_i,
  output ole_pkg::cmp_res_t                res_o
);

  always_comb begin
    res_o.eq = (a_i == b_i);
    res_o.lt = (a_i < b_i);
  end

endmodule

FILE: rtl/ordered_list_engine_top.sv
// ordered_list_engine_top: sequencer, command registers and result register
// depends on ole_pkg, ole_mem and ole_cmp
//
// Keeps a list of signed 32-bit entries in a single-port-read, single-port-write
// memory of CAPACITY entries plus an entry count n. One command beat is taken
// at a time; in_stall_o stays high until the command is worked off. Every
// command gives exactly one result beat, held in an output register so the
// block can go back to idle while the result waits. An insert at position
// p < n walks the tail from the top, one entry per cycle with reads and
// writes overlapped, then writes the key; an append only writes the key.
// A swap reads both entries, then writes them back crossed. Find and
// find-minimum scan upward from entry 0. The next command beat is taken in
// the cycle after the result register loads, and the load waits while an
// earlier result is still stalled there. The walk rate is set by the one
// memory read port, and the one shared compare unit does every key and
// minimum comparison.
// The store needs no clearing after reset: only entries below the count are
// ever read. An insert into a full list is dropped with status full, and a
// swap with either position at or past the count is ignored with status range.
module ordered_list_engine_top #(
  parameter int unsigned CAPACITY = ole_pkg::DEFAULT_CAPACITY
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // command channel
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [ole_pkg::CMD_W-1:0]           cmd_i,
  input  logic signed [ole_pkg::KEY_W-1:0]    key_i,
  input  logic [ole_pkg::POS_W-1:0]           pos_a_i,
  input  logic [ole_pkg::POS_W-1:0]           pos_b_i,
  // result channel
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                found_o,
  output logic [ole_pkg::INDEX_W-1:0]         index_o,
  output logic [ole_pkg::COUNT_W-1:0]         count_o,
  output logic [ole_pkg::STATUS_W-1:0]        status_o
);

  // address, count and compare widths
  localparam int unsigned AW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW  = $clog2(CAPACITY + 1);
  localparam int unsigned XW  = (CW > ole_pkg::POS_W) ? CW : ole_pkg::POS_W;
  localparam int unsigned IW  = ole_pkg::INDEX_W;
  localparam int unsigned NW  = ole_pkg::COUNT_W;
  localparam int unsigned KW  = ole_pkg::KEY_W;

  // sequencer states
  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_SHIFT   = 4'd1;
  localparam logic [3:0] S_DRAIN   = 4'd2;
  localparam logic [3:0] S_PUT     = 4'd3;
  localparam logic [3:0] S_SWAP_RA = 4'd4;
  localparam logic [3:0] S_SWAP_RB = 4'd5;
  localparam logic [3:0] S_SWAP_WA = 4'd6;
  localparam logic [3:0] S_SWAP_WB = 4'd7;
  localparam logic [3:0] S_SCAN    = 4'd8;
  localparam logic [3:0] S_RESP    = 4'd9;

  logic [3:0] state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;      // entry count
  logic [CW-1:0] ptr_q, ptr_d;      // walk pointer, may reach the count itself
  logic pend_q, pend_d;             // a read was issued last cycle
  logic [AW-1:0] pend_addr_q, pend_addr_d;

  // command registers
  logic [ole_pkg::CMD_W-1:0] cmd_q, cmd_d;
  logic [KW-1:0] key_q, key_d;
  logic [AW-1:0] pa_q, pa_d;
  logic [AW-1:0] pb_q, pb_d;
  logic [KW-1:0] hold_q, hold_d;    // swap temporary or running minimum

  // result being built
  logic res_found_q, res_found_d;
  logic [AW-1:0] res_index_q, res_index_d;
  logic [ole_pkg::STATUS_W-1:0] res_status_q, res_status_d;

  // output register
  logic out_valid_q;
  logic out_found_q;
  logic [IW-1:0] out_index_q;
  logic [NW-1:0] out_count_q;
  logic [ole_pkg::STATUS_W-1:0] out_status_q;
  logic out_load;

  // memory and compare unit
  logic mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [KW-1:0] mem_wdata, mem_rdata;
  logic [KW-1:0] cmp_b;
  ole_pkg::cmp_res_t cmp_res;

  // positions widened so that they compare against the count at any capacity
  logic [XW-1:0] pa_x, pb_x, cnt_x;
  logic scan_last;

  assign pa_x  = XW'(pos_a_i);
  assign pb_x  = XW'(pos_b_i);
  assign cnt_x = XW'(cnt_q);

  assign scan_last = ((CW'(pend_addr_q) + CW'(1)) == cnt_q);

  // find compares against the key, find-minimum against the best so far
  assign cmp_b = (cmd_q == ole_pkg::CMD_FIND) ? key_q : hold_q;

  ole_cmp u_cmp (
    .a_i   (mem_rdata),
    .b_i   (cmp_b),
    .res_o (cmp_res)
  );

  ole_mem #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    ptr_d        = ptr_q;
    pend_d       = 1'b0;
    pend_addr_d  = pend_addr_q;
    cmd_d        = cmd_q;
    key_d        = key_q;
    pa_d         = pa_q;
    pb_d         = pb_q;
    hold_d       = hold_q;
    res_found_d  = res_found_q;
    res_index_d  = res_index_q;
    res_status_d = res_status_q;
    mem_we       = 1'b0;
    mem_waddr    = pa_q;
    mem_wdata    = key_q;
    mem_re       = 1'b0;
    mem_raddr    = ptr_q[AW-1:0];
    out_load     = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_d        = cmd_i;
          key_d        = key_i;
          ptr_d        = '0;
          res_found_d  = 1'b0;
          res_index_d  = '0;
          res_status_d = ole_pkg::STAT_OK;
          unique case (cmd_i)
            ole_pkg::CMD_INSERT: begin
              if (cnt_q == CW'(CAPACITY)) begin
                res_status_d = ole_pkg::STAT_FULL;
                state_d      = S_RESP;
              end else if (pa_x < cnt_x) begin
                // open a gap at the position: walk the tail from the top
                pa_d    = pa_x[AW-1:0];
                ptr_d   = cnt_q - CW'(1);
                state_d = S_SHIFT;
              end else begin
                pa_d    = cnt_q[AW-1:0];
                state_d = S_PUT;
              end
            end
            ole_pkg::CMD_SWAP: begin
              if ((pa_x < cnt_x) && (pb_x < cnt_x)) begin
                pa_d    = pa_x[AW-1:0];
                pb_d    = pb_x[AW-1:0];
                state_d = S_SWAP_RA;
              end else begin
                res_status_d = ole_pkg::STAT_RANGE;
                state_d      = S_RESP;
              end
            end
            ole_pkg::CMD_FIND, ole_pkg::CMD_MIN: begin
              if (cnt_q == '0) begin
                state_d = S_RESP;
              end else begin
                // find-minimum always reports found on a non-empty list
                res_found_d = (cmd_i == ole_pkg::CMD_MIN);
                state_d     = S_SCAN;
              end
            end
          endcase
        end
      end

      S_SHIFT: begin
        // read entry ptr while the entry read last cycle moves up by one
        mem_re      = 1'b1;
        mem_raddr   = ptr_q[AW-1:0];
        mem_we      = pend_q;
        mem_waddr   = pend_addr_q + AW'(1);
        mem_wdata   = mem_rdata;
        pend_d      = 1'b1;
        pend_addr_d = ptr_q[AW-1:0];
        if (ptr_q[AW-1:0] == pa_q) begin
          state_d = S_DRAIN;
        end else begin
          ptr_d = ptr_q - CW'(1);
        end
      end

      S_DRAIN: begin
        mem_we    = 1'b1;
        mem_waddr = pend_addr_q + AW'(1);
        mem_wdata = mem_rdata;
        state_d   = S_PUT;
      end

      S_PUT: begin
        mem_we    = 1'b1;
        mem_waddr = pa_q;
        mem_wdata = key_q;
        cnt_d     = cnt_q + CW'(1);
        state_d   = S_RESP;
      end

      S_SWAP_RA: begin
        mem_re    = 1'b1;
        mem_raddr = pa_q;
        state_d   = S_SWAP_RB;
      end

      S_SWAP_RB: begin
        mem_re    = 1'b1;
        mem_raddr = pb_q;
        hold_d    = mem_rdata;
        state_d   = S_SWAP_WA;
      end

      S_SWAP_WA: begin
        mem_we    = 1'b1;
        mem_waddr = pa_q;
        mem_wdata = mem_rdata;
        state_d   = S_SWAP_WB;
      end

      S_SWAP_WB: begin
        mem_we    = 1'b1;
        mem_waddr = pb_q;
        mem_wdata = hold_q;
        state_d   = S_RESP;
      end

      S_SCAN: begin
        // issue reads upward, judge each entry in the cycle after its read
        if (ptr_q != cnt_q) begin
          mem_re      = 1'b1;
          mem_raddr   = ptr_q[AW-1:0];
          ptr_d       = ptr_q + CW'(1);
          pend_d      = 1'b1;
          pend_addr_d = ptr_q[AW-1:0];
        end
        if (pend_q) begin
          if (cmd_q == ole_pkg::CMD_FIND) begin
            if (cmp_res.eq) begin
              res_found_d = 1'b1;
              res_index_d = pend_addr_q;
              state_d     = S_RESP;
            end else if (scan_last) begin
              state_d = S_RESP;
            end
          end else begin
            // strict less-than keeps the first index on ties
            if ((pend_addr_q == '0) || cmp_res.lt) begin
              hold_d      = mem_rdata;
              res_index_d = pend_addr_q;
            end
            if (scan_last) begin
              state_d = S_RESP;
            end
          end
        end
      end

      S_RESP: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      pend_q  <= pend_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    ptr_q        <= ptr_d;
    pend_addr_q  <= pend_addr_d;
    cmd_q        <= cmd_d;
    key_q        <= key_d;
    pa_q         <= pa_d;
    pb_q         <= pb_d;
    hold_q       <= hold_d;
    res_found_q  <= res_found_d;
    res_index_q  <= res_index_d;
    res_status_q <= res_status_d;
    if (out_load) begin
      out_found_q  <= res_found_q;
      out_index_q  <= IW'(res_index_q);
      out_count_q  <= NW'(cnt_q);
      out_status_q <= res_status_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign found_o     = out_found_q;
  assign index_o     = out_index_q;
  assign count_o     = out_count_q;
  assign status_o    = out_status_q;

  // count never passes the capacity
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(CAPACITY))
    else $error("entry count above capacity");

  // count only grows, by one, at the end of an insert
  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != $past(cnt_q)) |->
      ((cnt_q == $past(cnt_q) + CW'(1)) && ($past(state_q) == S_PUT)))
    else $error("entry count changed outside an insert");

  // a dropped insert is reported only with a full list
  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && (res_status_q == ole_pkg::STAT_FULL)) |-> (cnt_q == CW'(CAPACITY)))
    else $error("full status with room left");

  // the shift never writes below the insert position
  a_shift_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SHIFT && pend_q) |-> (pend_addr_q >= pa_q))
    else $error("shift went below insert position");

  // an accepted command always leaves idle
  a_accept_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q != S_IDLE))
    else $error("accepted command did not start");

endmodule
